// ===== design/ordered_list_remove_engine_macros.svh =====
// Assertion macros shared by the ordered list remove engine modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef ORDERED_LIST_REMOVE_ENGINE_MACROS_SVH
`define ORDERED_LIST_REMOVE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define OLRE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define OLRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/olre_pkg.sv =====
// Package for the ordered list remove engine: word types, codes and defaults.
// Depends on nothing; used by every module of the block.
package olre_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 5;

  typedef logic [1:0] op_t;
  localparam op_t OP_APPEND     = 2'd0;
  localparam op_t OP_REMOVE_AT  = 2'd1;
  localparam op_t OP_REMOVE_VAL = 2'd2;

  typedef logic [1:0] stat_t;
  localparam stat_t STAT_DONE = 2'd0;
  localparam stat_t STAT_MISS = 2'd1;
  localparam stat_t STAT_FULL = 2'd2;

  typedef struct packed {
    op_t                      operation;
    logic signed [DATA_W-1:0] data_word;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_word;
    stat_t                    status;
    logic [CNT_OUT_W-1:0]     entry_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } olre_cmd_t;

endpackage

// ===== design/olre_ctrl.sv =====
// Controller of the ordered list remove engine: sequencing and handshakes.
// Depends on olre_pkg and the assertion macro header.
`include "ordered_list_remove_engine_macros.svh"

module olre_ctrl
  import olre_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output olre_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit_go;
  logic   in_accept;

  // A commit needs the output register free, or being emptied this cycle.
  assign commit_go = (state_r == ST_COMMIT) && (!out_valid_r || !out_stall);
  assign in_stall  = !((state_r == ST_IDLE) || commit_go);
  assign in_accept = in_valid && !in_stall;

  assign cmd.load   = in_accept;
  assign cmd.lookup = (state_r == ST_LOOKUP);
  assign cmd.commit = commit_go;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_go) state_nxt = in_accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = commit_go || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `OLRE_ASSERT_NEXT(a_lookup_then_commit, clk, rst_n, state_r == ST_LOOKUP, state_r == ST_COMMIT, "lookup not followed by commit")
  `OLRE_ASSERT_NEXT(a_commit_fills_output, clk, rst_n, commit_go, out_valid_r, "commit left no result word")
  `OLRE_ASSERT_IMPLY(a_no_accept_in_lookup, clk, rst_n, state_r == ST_LOOKUP, in_stall, "word accepted during lookup")

endmodule

// ===== design/olre_dp.sv =====
// Datapath of the ordered list remove engine: entry registers, search and shift.
// Depends on olre_pkg and the assertion macro header.
`include "ordered_list_remove_engine_macros.svh"

module olre_dp
  import olre_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  olre_cmd_t cmd,
  input  in_word_t  in_word,
  output out_word_t out_word
);

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  // Captured request.
  op_t                  op_r;
  logic [WORD_BITS-1:0] word_r;
  logic [POS_W-1:0]     pos_r;

  logic [WORD_BITS-1:0] entries_r [DEPTH];
  logic [COUNT_W-1:0]   count_r, count_nxt;

  // Lookup results.
  logic                 hit_r, hit_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  stat_t                status_r, status_nxt;

  out_word_t            out_r;

  logic [DEPTH-1:0]     match_vec;
  logic [IDX_W-1:0]     first_idx;
  logic                 found;
  logic                 pos_ok;
  logic                 full;
  logic                 append_go;
  logic                 remove_go;
  logic [WORD_BITS-1:0] removed;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_word.operation;
      word_r <= WORD_BITS'(in_word.data_word);
      pos_r  <= in_word.position;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_vec[i] = (entries_r[i] == word_r) && (COUNT_W'(i) < count_r);
    end
    found     = |match_vec;
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) first_idx = IDX_W'(i);
    end
  end

  assign pos_ok = CMP_W'(pos_r) < CMP_W'(count_r);
  assign full   = (count_r == COUNT_W'(DEPTH));

  always_comb begin
    hit_nxt    = 1'b0;
    idx_nxt    = '0;
    status_nxt = STAT_MISS;
    case (op_r)
      OP_APPEND: begin
        hit_nxt    = !full;
        status_nxt = full ? STAT_FULL : STAT_DONE;
      end
      OP_REMOVE_AT: begin
        hit_nxt    = pos_ok;
        idx_nxt    = IDX_W'(pos_r);
        status_nxt = pos_ok ? STAT_DONE : STAT_MISS;
      end
      OP_REMOVE_VAL: begin
        hit_nxt    = found;
        idx_nxt    = first_idx;
        status_nxt = found ? STAT_DONE : STAT_MISS;
      end
      default: begin
        hit_nxt    = 1'b0;
        status_nxt = STAT_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r    <= hit_nxt;
      idx_r    <= idx_nxt;
      status_r <= status_nxt;
    end
  end

  assign append_go = hit_r && (op_r == OP_APPEND);
  assign remove_go = hit_r && (op_r != OP_APPEND);
  assign removed   = remove_go ? entries_r[idx_r] : '0;

  always_comb begin
    count_nxt = count_r;
    if (append_go) count_nxt = count_r + COUNT_W'(1);
    else if (remove_go) count_nxt = count_r - COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Each entry holds, takes the appended word, or (but the last) its upper neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    if (g < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (cmd.commit) begin
          if (append_go && (count_r == COUNT_W'(g))) begin
            entries_r[g] <= word_r;
          end else if (remove_go && (IDX_W'(g) >= idx_r)) begin
            entries_r[g] <= entries_r[g + 1];
          end
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.commit && append_go && (count_r == COUNT_W'(g))) begin
          entries_r[g] <= word_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.removed_word <= DATA_W'(removed);
      out_r.status       <= status_r;
      out_r.entry_count  <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_word = out_r;

  `OLRE_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= COUNT_W'(DEPTH), "count above depth")
  `OLRE_ASSERT_NEXT(a_miss_keeps_count, clk, rst_n, cmd.commit && (status_r == STAT_MISS), $stable(count_r), "count moved on a miss")
  `OLRE_ASSERT_NEXT(a_full_stays_full, clk, rst_n, cmd.commit && (status_r == STAT_FULL), count_r == COUNT_W'(DEPTH), "full list changed size")

endmodule

// ===== design/ordered_list_remove_engine.sv =====
// Top level of the ordered list remove engine: controller plus datapath.
// Depends on olre_pkg, olre_ctrl and olre_dp.
//
//   Channel   Direction  Handshake            Word
//   in        input      in_valid/in_stall    in_word_t  (operation, data_word, position)
//   out       output     out_valid/out_stall  out_word_t (removed_word, status, entry_count)
//
// Each request passes through two states: a lookup state that checks the
// position or compares the sought word against every held entry in parallel
// and picks the first match, then a commit state that appends the word or
// shifts the entries above the removed one down by one place and registers
// the result word. A new word is taken while idle or as the last one commits.
// A stalled result holds the commit, and with it the next request, in place.
// Reset clears the entry count and the control state; entry contents are not
// cleared, since entries at or above the count never reach a result.
module ordered_list_remove_engine
  import olre_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // Command bundle from controller to datapath.
  olre_cmd_t cmd;

  // The controller owns the sequence and both handshakes.
  olre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the list, the request and the result register.
  olre_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule

// ===== verif/ordered_list_remove_engine_tb.sv =====
// Self-checking testbench for ordered_list_remove_engine: a directed table, then random requests.
// Each result is checked against a list predictor held in the bench, or against one written out by hand.
// Depends on olre_pkg and the ordered_list_remove_engine RTL.
`timescale 1ns / 1ps

module ordered_list_remove_engine_tb;
  import olre_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_WORDS = 1950;
  // The long receiver hold-off starts once this many request words are in.
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_LIMIT  = 5000;

  // Operation code 3 has no meaning. The block must answer it with a miss.
  localparam op_t OP_UNUSED = 2'd3;

  typedef logic signed [DATA_W-1:0] list_word_t;

  // One row of the directed part. When typed is set, res holds the result
  // written out by hand. Otherwise the predictor supplies it.
  typedef struct {
    in_word_t  req;
    bit        typed;
    out_word_t res;
  } script_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  // The bench's own copy of the list, front entry first.
  list_word_t  shadow_list[$];
  // Results still owed by the block, oldest first.
  out_word_t   replies_due[$];
  script_row_t script_rows[$];

  int mismatches = 0;
  int words_sent = 0;
  // The random requests lean toward appends while this is set and toward
  // removes otherwise, so the list keeps sweeping between empty and full.
  bit growing    = 1'b1;

  // These words fill the list in the directed part. They include both
  // extremes, minus one, zero and a duplicate pair.
  list_word_t fill_words[LIST_DEPTH] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
    5, 5, 1, 2, 3, 4, 6, 7, 8, 9, 10, 11
  };

  ordered_list_remove_engine #(
    .DEPTH    (LIST_DEPTH),
    .WORD_BITS(WORD_BITS_DEF)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run must be over well before this.
  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 200) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Applies one accepted request to the list copy and returns the result the
  // block owes for it. An append to a full list is dropped. A remove that
  // finds nothing, and the unused code, leave the list as it is.
  function automatic out_word_t list_apply(input in_word_t req);
    out_word_t res;
    int        hit;
    res.removed_word = '0;
    res.status       = STAT_MISS;
    hit              = -1;
    case (req.operation)
      OP_APPEND: begin
        if (shadow_list.size() >= LIST_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          shadow_list.push_back(req.data_word);
          res.status = STAT_DONE;
        end
      end
      OP_REMOVE_AT: begin
        if (int'(req.position) < shadow_list.size()) begin
          hit = int'(req.position);
        end
      end
      OP_REMOVE_VAL: begin
        // The first match from the front wins.
        foreach (shadow_list[i]) begin
          if (hit < 0 && shadow_list[i] == req.data_word) begin
            hit = i;
          end
        end
      end
      default: ;
    endcase
    if (hit >= 0) begin
      res.removed_word = shadow_list[hit];
      shadow_list.delete(hit);
      res.status = STAT_DONE;
    end
    res.entry_count = CNT_OUT_W'(shadow_list.size());
    return res;
  endfunction

  // Half the values are small, so duplicates and matches are common. Some values
  // are fully random, and the extremes come up now and then.
  function automatic list_word_t any_list_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      return $urandom_range(0, 7) - 4;
    end else if (pick < 8) begin
      return $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'hffff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
  endfunction

  // Builds one random request, shaped by the current contents of the list.
  function automatic in_word_t pick_request();
    in_word_t req;
    int       roll;
    int       held;
    held = shadow_list.size();
    // Turn around at the ends. Sometimes the bias stays put at a full list,
    // so appends keep hitting the full case for a while.
    if (held == 0) begin
      growing = 1'b1;
    end else if (held == LIST_DEPTH && $urandom_range(0, 3) != 0) begin
      growing = 1'b0;
    end else if ($urandom_range(0, 49) == 0) begin
      growing = ~growing;
    end
    req.data_word = any_list_word();
    req.position  = POS_W'($urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      req.operation = OP_UNUSED;
    end else if (roll < (growing ? 65 : 30)) begin
      req.operation = OP_APPEND;
    end else if (roll < (growing ? 82 : 65)) begin
      req.operation = OP_REMOVE_AT;
      if (held > 0 && $urandom_range(0, 4) != 0) begin
        req.position = POS_W'($urandom_range(0, held - 1));
      end
    end else begin
      req.operation = OP_REMOVE_VAL;
      if (held > 0 && $urandom_range(0, 4) != 0) begin
        req.data_word = shadow_list[$urandom_range(0, held - 1)];
      end
    end
    return req;
  endfunction

  task automatic add_row(input op_t op, input list_word_t data, input int pos, input bit typed,
                         input list_word_t removed, input stat_t st, input int cnt);
    script_row_t row;
    row.req.operation    = op;
    row.req.data_word    = data;
    row.req.position     = POS_W'(pos);
    row.typed            = typed;
    row.res.removed_word = removed;
    row.res.status       = st;
    row.res.entry_count  = CNT_OUT_W'(cnt);
    script_rows.push_back(row);
  endtask

  // Offers one request word and holds it steady until the block takes it.
  // The expected result is recorded at the edge where the word is accepted.
  // in_valid is left high, so the next word can follow without a gap.
  task automatic offer_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t predicted;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    predicted = list_apply(w);
    replies_due.push_back(typed ? typed_res : predicted);
    words_sent++;
  endtask

  // Result side. A word counts at an edge where out_valid is high and
  // out_stall is low, both seen as they stood just before the edge.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        flag_mismatch($sformatf("result word with none expected: %p", out_word));
      end else begin
        want = replies_due.pop_front();
        if (out_word.removed_word !== want.removed_word) begin
          flag_mismatch($sformatf("removed_word %0d, expected %0d",
                                  out_word.removed_word, want.removed_word));
        end
        if (out_word.status !== want.status) begin
          flag_mismatch($sformatf("status %0d, expected %0d", out_word.status, want.status));
        end
        if (out_word.entry_count !== want.entry_count) begin
          flag_mismatch($sformatf("entry_count %0d, expected %0d",
                                  out_word.entry_count, want.entry_count));
        end
      end
    end
  end

  // The receiver stalls in segments. Each segment has its own pattern: no
  // stall, light random stall, heavy random stall, or a fixed rhythm. Once in
  // the run it holds off for a long stretch while the sender keeps offering
  // words. The block then fills up and has to stall its input.
  initial begin : result_sink
    int  mode;
    int  span;
    int  k;
    bit  held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        if (!held_off && words_sent >= HOLD_AT) begin
          held_off = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (k % 4 == 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    int burst_left;
    int gap;
    int drain;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    burst_left = 0;

    // Directed part. It starts with removes and the unused code on an empty
    // list. Then it fills the list to the brim and appends once more, which
    // must be dropped. Then it removes at the back, by a duplicated value and
    // at the front, makes a search that finds nothing and ends with the unused code.
    add_row(OP_REMOVE_AT,  0, 0, 1'b1, 0, STAT_MISS, 0);
    add_row(OP_REMOVE_VAL, 0, 0, 1'b1, 0, STAT_MISS, 0);
    add_row(OP_UNUSED,    -1, 15, 1'b1, 0, STAT_MISS, 0);
    for (int k = 0; k < LIST_DEPTH; k++) begin
      add_row(OP_APPEND, fill_words[k], k, 1'b1, 0, STAT_DONE, k + 1);
    end
    add_row(OP_APPEND, 32'h1234_5678, 15, 1'b1, 0, STAT_FULL, LIST_DEPTH);
    add_row(OP_REMOVE_AT,  0, 15, 1'b0, 0, STAT_DONE, 0);
    add_row(OP_REMOVE_VAL, 5, 0, 1'b0, 0, STAT_DONE, 0);
    add_row(OP_REMOVE_AT,  0, 0, 1'b0, 0, STAT_DONE, 0);
    add_row(OP_REMOVE_VAL, 12345, 9, 1'b1, 0, STAT_MISS, LIST_DEPTH - 3);
    add_row(OP_UNUSED, 32'h7fff_ffff, 6, 1'b1, 0, STAT_MISS, LIST_DEPTH - 3);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_rows[i]) begin
      offer_word(script_rows[i].req, script_rows[i].typed, script_rows[i].res);
    end

    // Random part. The sender works in bursts. Between two bursts it may pause,
    // or it may carry straight on.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      offer_word(pick_request(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Wait for every owed result, then keep watching the output, so that a stray
    // extra result word still gets caught.
    drain = 0;
    while (replies_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (replies_due.size() != 0) begin
      flag_mismatch($sformatf("%0d result words never arrived", replies_due.size()));
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/olre_pkg.sv
design/olre_ctrl.sv
design/olre_dp.sv
design/ordered_list_remove_engine.sv
verif/ordered_list_remove_engine_tb.sv
